// ----- hw/rtl/dwsp_pkg.sv -----
// Package for the dual-wheel speed PID: register codes, config struct,
// sequencer states, MAC control struct and the 32-bit saturation helper.
// No dependencies.
`default_nettype none

package dwsp_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = 48;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W      = 38;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP         = 4'd0,
        REG_KI         = 4'd1,
        REG_KD         = 4'd2,
        REG_YAW_GAIN   = 4'd3,
        REG_YAW_LIMIT  = 4'd4,
        REG_HOME_STOP  = 4'd5,
        REG_STARTUP    = 4'd6,
        REG_HOME_SPEED = 4'd7
    } cfg_reg_t;

    localparam logic signed [15:0] RST_KP         = 16'sd492;
    localparam logic signed [15:0] RST_KI         = 16'sd0;
    localparam logic signed [15:0] RST_KD         = 16'sd0;
    localparam logic [11:0]        RST_YAW_GAIN   = 12'd410;
    localparam logic [14:0]        RST_YAW_LIMIT  = 15'd80;
    localparam logic [23:0]        RST_HOME_STOP  = 24'd1500;
    localparam logic [15:0]        RST_STARTUP    = 16'd50;
    localparam logic [14:0]        RST_HOME_SPEED = 15'd218;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic [11:0]        yaw_gain;
        logic [14:0]        yaw_limit;
        logic [23:0]        home_stop;
        logic [15:0]        startup_ticks;
        logic [14:0]        home_speed;
    } cfg_t;

    typedef struct packed {
        logic acc_clr;
        logic acc_add;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_YAW_MUL,
        S_YAW_ADD,
        S_ERR,
        S_SUM,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_DRIVE,
        S_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v[39:31] != {9{v[39]}})
        begin
            r = v[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dual_wheel_speed_pid.sv -----
// Top level of the dual-wheel incremental PID speed controller: sequencer,
// wheel state and result register. Depends on dwsp_pkg, dwsp_cfg, dwsp_mac.
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+------------------------
//  in      | in_valid/in_ready, nine fields   | input     | in_valid & in_ready
//  out     | out_valid/out_ready, 3 fields    | output    | out_valid & out_ready
//  cfg     | cfg_valid/cfg_ready, index, data | input     | cfg_valid & cfg_ready
//
// An item with run set passes prep, yaw multiply and yaw add, then 7 steps per
// wheel on the one shared multiplier, before its result; run low goes straight to it.
// in_ready is high only while the sequencer is idle; the result sits in an
// output register so the next item can start while it waits.
// A stalled result only holds the sequencer at its final step.
// Reset loads the register defaults and clears all wheel state.
`default_nettype none

module dual_wheel_speed_pid (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  target_left,
    input  logic signed [15:0]                  target_right,
    input  logic signed [15:0]                  yaw_rate,
    input  logic signed [15:0]                  measured_left,
    input  logic signed [15:0]                  measured_right,
    input  logic [23:0]                         home_distance,
    input  logic                                in_home,
    input  logic [15:0]                         tick_count,
    input  logic                                run,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [31:0]                  drive_left,
    output logic signed [31:0]                  drive_right,
    output logic                                updated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dwsp_pkg::*;

    cfg_t     cfg;
    mac_ctl_t mac_ctl;
    state_t   state_reg;
    state_t   state_next;

    logic signed [15:0]        op_a;
    logic signed [31:0]        op_b;
    logic signed [SHIFT_W-1:0] prod_shift;
    logic signed [ACC_W-1:0]   acc;

    // latched item
    logic signed [15:0] tl_reg, tr_reg, yaw_reg, ml_reg, mr_reg;
    logic [23:0]        hd_reg;
    logic               home_reg;
    logic [15:0]        sc_reg;
    logic               run_reg;

    // working registers
    logic signed [15:0] tl_b_reg, tr_b_reg, y_c_reg;
    logic               yaw_on_reg;
    logic signed [16:0] set_l_reg, set_r_reg;
    logic signed [17:0] e_reg;
    logic signed [18:0] de_reg;
    logic               wheel_sel_reg;

    // wheel state, index 0 left, 1 right
    logic signed [17:0] prev_err_reg [2];
    logic signed [31:0] err_sum_reg  [2];
    logic signed [31:0] drive_reg    [2];

    logic               out_valid_reg;
    logic signed [31:0] drive_left_reg, drive_right_reg;
    logic               updated_reg;

    // combinational helpers
    logic signed [16:0] y_ext, lim_pos, lim_neg;
    logic signed [15:0] y_clamp;
    logic signed [15:0] yaw_t;
    logic signed [16:0] set_sel;
    logic signed [15:0] meas_sel;
    logic signed [32:0] sum_wide;
    logic signed [39:0] drive_wide;
    logic               load_out;

    dwsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dwsp_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mac_ctl),
        .op_a       (op_a),
        .op_b       (op_b),
        .prod_shift (prod_shift),
        .acc        (acc)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign drive_left  = drive_left_reg;
    assign drive_right = drive_right_reg;
    assign updated     = updated_reg;

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        y_ext   = {yaw_reg[15], yaw_reg};
        lim_pos = {2'b00, cfg.yaw_limit};
        lim_neg = -lim_pos;
        if (y_ext > lim_pos)
        begin
            y_clamp = lim_pos[15:0];
        end
        else if (y_ext < lim_neg)
        begin
            y_clamp = lim_neg[15:0];
        end
        else
        begin
            y_clamp = yaw_reg;
        end
        yaw_t      = yaw_on_reg ? prod_shift[15:0] : 16'sd0;
        set_sel    = wheel_sel_reg ? set_r_reg : set_l_reg;
        meas_sel   = wheel_sel_reg ? mr_reg : ml_reg;
        sum_wide   = {err_sum_reg[wheel_sel_reg][31], err_sum_reg[wheel_sel_reg]}
                   + {{15{e_reg[17]}}, e_reg};
        drive_wide = {{8{drive_reg[wheel_sel_reg][31]}}, drive_reg[wheel_sel_reg]}
                   + {{(40-ACC_W){acc[ACC_W-1]}}, acc};
    end

    // sequencer: next state, multiplier operands, accumulator control
    always_comb
    begin
        state_next      = state_reg;
        op_a            = '0;
        op_b            = '0;
        mac_ctl.acc_clr = 1'b0;
        mac_ctl.acc_add = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = run ? S_PREP : S_OUT;
                end
            end
            S_PREP:    state_next = S_YAW_MUL;
            S_YAW_MUL:
            begin
                op_a       = {4'b0000, cfg.yaw_gain};
                op_b       = {{16{y_c_reg[15]}}, y_c_reg};
                state_next = S_YAW_ADD;
            end
            S_YAW_ADD: state_next = S_ERR;
            S_ERR:     state_next = S_SUM;
            S_SUM:     state_next = S_MUL_P;
            S_MUL_P:
            begin
                op_a            = cfg.kp;
                op_b            = {{14{e_reg[17]}}, e_reg};
                mac_ctl.acc_clr = 1'b1;
                state_next      = S_MUL_I;
            end
            S_MUL_I:
            begin
                op_a            = cfg.ki;
                op_b            = err_sum_reg[wheel_sel_reg];
                mac_ctl.acc_add = 1'b1;
                state_next      = S_MUL_D;
            end
            S_MUL_D:
            begin
                op_a            = cfg.kd;
                op_b            = {{13{de_reg[18]}}, de_reg};
                mac_ctl.acc_add = 1'b1;
                state_next      = S_ACC;
            end
            S_ACC:
            begin
                mac_ctl.acc_add = 1'b1;
                state_next      = S_DRIVE;
            end
            S_DRIVE:   state_next = wheel_sel_reg ? S_OUT : S_ERR;
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item latch and working values
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tl_reg   <= target_left;
            tr_reg   <= target_right;
            yaw_reg  <= yaw_rate;
            ml_reg   <= measured_left;
            mr_reg   <= measured_right;
            hd_reg   <= home_distance;
            home_reg <= in_home;
            sc_reg   <= tick_count;
            run_reg  <= run;
        end
        if (state_reg == S_PREP)
        begin
            y_c_reg <= y_clamp;
            if (hd_reg >= cfg.home_stop)
            begin
                tl_b_reg <= '0;
                tr_b_reg <= '0;
            end
            else if (home_reg)
            begin
                tl_b_reg <= '0;
                tr_b_reg <= {1'b0, cfg.home_speed};
            end
            else
            begin
                tl_b_reg <= tl_reg;
                tr_b_reg <= tr_reg;
            end
            yaw_on_reg <= (hd_reg < cfg.home_stop) && !home_reg
                          && (sc_reg > cfg.startup_ticks);
        end
        if (state_reg == S_YAW_ADD)
        begin
            set_l_reg <= {tl_b_reg[15], tl_b_reg} + {yaw_t[15], yaw_t};
            set_r_reg <= {tr_b_reg[15], tr_b_reg} - {yaw_t[15], yaw_t};
        end
        if (state_reg == S_ERR)
        begin
            e_reg <= {set_sel[16], set_sel} - {{2{meas_sel[15]}}, meas_sel};
        end
        if (state_reg == S_SUM)
        begin
            de_reg <= {e_reg[17], e_reg}
                      - {prev_err_reg[wheel_sel_reg][17], prev_err_reg[wheel_sel_reg]};
        end
        if (load_out)
        begin
            drive_left_reg  <= drive_reg[0];
            drive_right_reg <= drive_reg[1];
            updated_reg     <= run_reg;
        end
    end

    // wheel state and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_sel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prev_err_reg[i] <= '0;
                err_sum_reg[i]  <= '0;
                drive_reg[i]    <= '0;
            end
        end
        else
        begin
            if (state_reg == S_YAW_ADD)
            begin
                wheel_sel_reg <= 1'b0;
            end
            if (state_reg == S_SUM)
            begin
                err_sum_reg[wheel_sel_reg]  <= sat32({{7{sum_wide[32]}}, sum_wide});
                prev_err_reg[wheel_sel_reg] <= e_reg;
            end
            if (state_reg == S_DRIVE)
            begin
                drive_reg[wheel_sel_reg] <= sat32(drive_wide);
                wheel_sel_reg            <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_run_low_skips: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !run |=> state_reg == S_OUT)
        else $error("run-low item did not go straight to result");

    a_left_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_YAW_ADD |=> !wheel_sel_reg)
        else $error("wheel select not on left after yaw step");

    a_right_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRIVE && wheel_sel_reg |=> state_reg == S_OUT)
        else $error("right wheel drive update not followed by result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

endmodule

`default_nettype wire

// ----- hw/rtl/dwsp_cfg.sv -----
// Configuration register file for the dual-wheel speed PID.
// Depends on dwsp_pkg.
`default_nettype none

module dwsp_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dwsp_pkg::cfg_t                      cfg
);
    import dwsp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KP:         cfg_next.kp            = cfg_data[15:0];
                REG_KI:         cfg_next.ki            = cfg_data[15:0];
                REG_KD:         cfg_next.kd            = cfg_data[15:0];
                REG_YAW_GAIN:   cfg_next.yaw_gain      = cfg_data[11:0];
                REG_YAW_LIMIT:  cfg_next.yaw_limit     = cfg_data[14:0];
                REG_HOME_STOP:  cfg_next.home_stop     = cfg_data[23:0];
                REG_STARTUP:    cfg_next.startup_ticks = cfg_data[15:0];
                REG_HOME_SPEED: cfg_next.home_speed    = cfg_data[14:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp            <= RST_KP;
            cfg_reg.ki            <= RST_KI;
            cfg_reg.kd            <= RST_KD;
            cfg_reg.yaw_gain      <= RST_YAW_GAIN;
            cfg_reg.yaw_limit     <= RST_YAW_LIMIT;
            cfg_reg.home_stop     <= RST_HOME_STOP;
            cfg_reg.startup_ticks <= RST_STARTUP;
            cfg_reg.home_speed    <= RST_HOME_SPEED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dwsp_mac.sv -----
// Shared multiply-accumulate unit: registered 16x32 signed product,
// Q12 arithmetic shift and a wide accumulator. Depends on dwsp_pkg.
`default_nettype none

module dwsp_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dwsp_pkg::mac_ctl_t                     ctl,
    input  logic signed [15:0]                     op_a,
    input  logic signed [31:0]                     op_b,
    output logic signed [dwsp_pkg::SHIFT_W-1:0]    prod_shift,
    output logic signed [dwsp_pkg::ACC_W-1:0]      acc
);
    import dwsp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  addend;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // drop the fraction bits: floor shift of the product
    assign prod_shift = prod_reg[PROD_W-1:FRAC_BITS];

    always_comb
    begin
        addend   = ctl.acc_add ? {{(ACC_W-SHIFT_W){prod_shift[SHIFT_W-1]}}, prod_shift}
                               : '0;
        acc_next = (ctl.acc_clr ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire
